FILE: src/ppm_frame_decoder_motor_drive_macros.svh
// Assertion macros used by the checker of the PPM frame decoder.
`ifndef PPM_FRAME_DECODER_MOTOR_DRIVE_MACROS_SVH
`define PPM_FRAME_DECODER_MOTOR_DRIVE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPMFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ppmfd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PPMFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ppmfd assertion failed");

`endif

FILE: src/ppmfd_pkg.sv
// Types and constants of the PPM frame decoder with motor drive.
package ppmfd_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned WIDTH_W  = 16;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned THR_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MAG_W    = 10;
  localparam int unsigned SCALED_W = 11;

  localparam logic [WIDTH_W-1:0] SYNC_RESET = 16'd3000;
  localparam logic [THR_W-1:0]   THR_RESET  = 3'd1;

  localparam logic [WIDTH_W-1:0] DB_LOW    = 16'd1480;
  localparam logic [WIDTH_W-1:0] DB_HIGH   = 16'd1520;
  localparam logic [WIDTH_W-1:0] REV_BASE  = 16'd1000;
  localparam logic [MAG_W-1:0]   MAG_LIMIT = 10'd1000;
  localparam logic [DUTY_W-1:0]  FULL_DUTY = 8'd220;
  localparam logic [DUTY_W-1:0]  MAX_DUTY  = 8'd255;

  // Multiplying by RECIP_3 and shifting right by RECIP_SHIFT divides by three.
  localparam logic [9:0] RECIP_3     = 10'd683;
  localparam int unsigned RECIP_SHIFT = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_THRESHOLD   = 2'd0,
    CFG_THROTTLE_CHANNEL = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DRV_STOP     = 2'd0,
    DRV_FWD      = 2'd1,
    DRV_REV_NEAR = 2'd2,
    DRV_REV_FAR  = 2'd3
  } drive_mode_e;

endpackage

FILE: src/ppmfd_if.sv
// Request channels of the PPM frame decoder: configuration, edge input, drive result.
interface ppmfd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ppmfd_pkg::CFG_IDX_W-1:0]     index;
  logic [ppmfd_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface ppmfd_edge_if;
  logic                             valid;
  logic                             ready;
  logic [ppmfd_pkg::TIME_W-1:0]     edge_time;

  modport source (output valid, output edge_time, input ready);
  modport sink (input valid, input edge_time, output ready);
endinterface

interface ppmfd_drive_if;
  logic                             valid;
  logic                             ready;
  logic [ppmfd_pkg::DUTY_W-1:0]     forward_duty;
  logic [ppmfd_pkg::DUTY_W-1:0]     reverse_duty;
  logic                             in_deadband;
  logic [ppmfd_pkg::WIDTH_W-1:0]    throttle_width;

  modport source (output valid, output forward_duty, output reverse_duty,
                  output in_deadband, output throttle_width, input ready);
  modport sink (input valid, input forward_duty, input reverse_duty,
                input in_deadband, input throttle_width, output ready);
endinterface

FILE: src/ppm_frame_decoder_motor_drive.sv
// Top level of the PPM frame decoder that turns the throttle channel into motor duties.
//
//  Channel  Dir  Payload                                           Request
//  cfg_i    in   index, data (sync threshold, throttle channel)   register write
//  edge_i   in   edge_time                                         one falling PPM edge
//  drive_o  out  forward_duty, reverse_duty, in_deadband, width    one drive result
//
// An edge request is accepted in every cycle while the pipeline moves.
// The drive result of a frame passes the stages s0, s1, s2, s3 and the output register.
// Each stage holds its contents while the stage after it is full and stalled.
// Reset clears the frame index, last edge time and valid flags, and presets the config.
module ppm_frame_decoder_motor_drive #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  ppmfd_cfg_if.sink     cfg_i,
  ppmfd_edge_if.sink    edge_i,
  ppmfd_drive_if.source drive_o
);
  import ppmfd_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(CHANNELS + 1);

  logic [WIDTH_W-1:0] sync_q;
  logic [THR_W-1:0]   thr_q;

  logic [TIME_W-1:0]  last_q;
  logic [CNT_W-1:0]   idx_q;
  logic [WIDTH_W-1:0] store_q [CHANNELS];

  logic               s0_v_q, s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic [TIME_W-1:0]  s0_time_q;
  logic [WIDTH_W-1:0] s1_width_q;
  logic [WIDTH_W-1:0] s2_width_q, s3_width_q;
  drive_mode_e        s2_mode_q, s3_mode_q;
  logic [MAG_W-1:0]   s2_mag_q;
  logic [SCALED_W-1:0] s3_scaled_q;
  logic [DUTY_W-1:0]  fwd_q, rev_q;
  logic               db_q;
  logic [WIDTH_W-1:0] width_q;

  logic rdy_out, rdy3, rdy2, rdy1, s0_fire;

  logic [TIME_W-1:0]  interval;
  logic [WIDTH_W-1:0] interval16;
  logic               is_sync, can_store, frame_done;
  logic [IDX_W-1:0]   sel, wr_idx;
  logic [WIDTH_W-1:0] sel_width;

  drive_mode_e        mode_d;
  logic [MAG_W-1:0]   mag_d;
  logic [WIDTH_W-1:0] fwd_over;
  logic [13:0]        mag_x11;
  logic [SCALED_W-1:0] scaled_d;
  logic [20:0]        div_prod;
  logic [8:0]         quot;
  logic [9:0]         far_sum;
  logic [DUTY_W-1:0]  fwd_d, rev_d;
  logic               db_d;

  assign rdy_out = !out_v_q || drive_o.ready;
  assign rdy3    = !s3_v_q || rdy_out;
  assign rdy2    = !s2_v_q || rdy3;
  assign rdy1    = !s1_v_q || rdy2;
  assign s0_fire = s0_v_q && rdy1;

  assign edge_i.ready = !s0_v_q || rdy1;
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
      thr_q  <= THR_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_SYNC_THRESHOLD:   sync_q <= cfg_i.data;
        CFG_THROTTLE_CHANNEL: thr_q  <= cfg_i.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame tracking on the registered edge.
  always_comb begin
    interval   = s0_time_q - last_q;
    interval16 = interval[WIDTH_W-1:0];
    is_sync    = interval > TIME_W'(sync_q);
    can_store  = idx_q < CNT_W'(CHANNELS);
    frame_done = !is_sync && (idx_q == CNT_W'(CHANNELS - 1));
    wr_idx     = idx_q[IDX_W-1:0];
    if (32'(thr_q) >= CHANNELS) begin
      sel = IDX_W'(CHANNELS - 1);
    end else begin
      sel = IDX_W'(thr_q);
    end
    if (sel == IDX_W'(CHANNELS - 1)) begin
      sel_width = interval16;
    end else begin
      sel_width = store_q[sel];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      idx_q  <= '0;
    end else if (s0_fire) begin
      last_q <= s0_time_q;
      if (is_sync) begin
        idx_q <= '0;
      end else if (can_store) begin
        idx_q <= CNT_W'(idx_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_fire && !is_sync && can_store) begin
      store_q[wr_idx] <= interval16;
    end
  end

  // Drive law: mode and magnitude of the width offset.
  always_comb begin
    fwd_over = s1_width_q - DB_HIGH;
    mode_d   = DRV_STOP;
    mag_d    = '0;
    priority if (s1_width_q > DB_HIGH) begin
      mode_d = DRV_FWD;
      mag_d  = (fwd_over > WIDTH_W'(MAG_LIMIT)) ? MAG_LIMIT : fwd_over[MAG_W-1:0];
    end else if (s1_width_q >= DB_LOW) begin
      mode_d = DRV_STOP;
    end else if (s1_width_q >= REV_BASE) begin
      mode_d = DRV_REV_NEAR;
      mag_d  = MAG_W'(s1_width_q - REV_BASE);
    end else begin
      mode_d = DRV_REV_FAR;
      mag_d  = MAG_W'(REV_BASE - s1_width_q);
    end
  end

  // Scaling by 220/480 is a multiply by 11, a shift by 3 and a divide by 3.
  always_comb begin
    mag_x11  = (14'(s2_mag_q) << 3) + (14'(s2_mag_q) << 1) + 14'(s2_mag_q);
    scaled_d = mag_x11[13:3];
  end

  always_comb begin
    div_prod = 21'(s3_scaled_q) * 21'(RECIP_3);
    quot     = div_prod[RECIP_SHIFT +: 9];
    far_sum  = 10'(FULL_DUTY) + 10'(quot);
    fwd_d    = '0;
    rev_d    = '0;
    db_d     = 1'b0;
    unique case (s3_mode_q)
      DRV_STOP: db_d = 1'b1;
      DRV_FWD: fwd_d = (quot > 9'(MAX_DUTY)) ? MAX_DUTY : quot[DUTY_W-1:0];
      DRV_REV_NEAR: rev_d = FULL_DUTY - quot[DUTY_W-1:0];
      DRV_REV_FAR: rev_d = (far_sum > 10'(MAX_DUTY)) ? MAX_DUTY : far_sum[DUTY_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (edge_i.ready) begin
        s0_v_q <= edge_i.valid;
      end
      if (rdy1) begin
        s1_v_q <= s0_fire && frame_done;
      end
      if (rdy2) begin
        s2_v_q <= s1_v_q;
      end
      if (rdy3) begin
        s3_v_q <= s2_v_q;
      end
      if (rdy_out) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_i.ready) begin
      s0_time_q <= edge_i.edge_time;
    end
    if (rdy1) begin
      s1_width_q <= sel_width;
    end
    if (rdy2) begin
      s2_width_q <= s1_width_q;
      s2_mode_q  <= mode_d;
      s2_mag_q   <= mag_d;
    end
    if (rdy3) begin
      s3_width_q  <= s2_width_q;
      s3_mode_q   <= s2_mode_q;
      s3_scaled_q <= scaled_d;
    end
    if (rdy_out) begin
      fwd_q   <= fwd_d;
      rev_q   <= rev_d;
      db_q    <= db_d;
      width_q <= s3_width_q;
    end
  end

  assign drive_o.valid          = out_v_q;
  assign drive_o.forward_duty   = fwd_q;
  assign drive_o.reverse_duty   = rev_q;
  assign drive_o.in_deadband    = db_q;
  assign drive_o.throttle_width = width_q;

endmodule

FILE: src/ppmfd_checker.sv
// Port checker of the PPM frame decoder, bound to the top level.
`include "ppm_frame_decoder_motor_drive_macros.svh"

module ppmfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  forward_duty,
  input logic [7:0]  reverse_duty,
  input logic        in_deadband,
  input logic [15:0] throttle_width
);
  import ppmfd_pkg::*;

  `PPMFD_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(forward_duty) && $stable(reverse_duty) && $stable(throttle_width))
  `PPMFD_ASSERT_NOW(a_deadband_flag, clk_i, rst_ni, out_valid, in_deadband == (throttle_width >= DB_LOW && throttle_width <= DB_HIGH))
  `PPMFD_ASSERT_NOW(a_deadband_stop, clk_i, rst_ni, out_valid && in_deadband, forward_duty == 8'd0 && reverse_duty == 8'd0)
  `PPMFD_ASSERT_NOW(a_forward_side, clk_i, rst_ni, out_valid && forward_duty != 8'd0, throttle_width > DB_HIGH)
  `PPMFD_ASSERT_NOW(a_reverse_side, clk_i, rst_ni, out_valid && reverse_duty != 8'd0, throttle_width < DB_LOW)

endmodule

bind ppm_frame_decoder_motor_drive ppmfd_checker u_ppmfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (drive_o.valid),
  .out_ready      (drive_o.ready),
  .forward_duty   (drive_o.forward_duty),
  .reverse_duty   (drive_o.reverse_duty),
  .in_deadband    (drive_o.in_deadband),
  .throttle_width (drive_o.throttle_width)
);
